// ===== rtl/core/wtps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wtps_pkg;

    localparam int MAX_WORD = 64;
    localparam int WORD_AW  = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
    localparam int LEN_W    = $clog2(MAX_WORD + 1);

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_tag;
        logic       pair_end;
        logic       truncated;
        logic       last;
    } out_beat_t;

    typedef enum logic [1:0] {
        PLAN_NONE,
        PLAN_ONE,
        PLAN_TWO,
        PLAN_BURST
    } plan_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MARK,
        ST_FETCH,
        ST_SEND
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic load_mark;
        logic rd_en;
        logic load_mem;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        plan_t plan;
        logic  out_free;
        logic  burst_last;
    } ctl_stat_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wtps_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wtps_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wtps_pkg::ctl_stat_t stat,
    output wtps_pkg::ctl_cmd_t  cmd
);
    import wtps_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = stat.out_free;
                if (s_valid && stat.out_free) begin
                    cmd.accept = 1'b1;
                    case (stat.plan)
                        PLAN_TWO:   state_next = ST_MARK;
                        PLAN_BURST: state_next = ST_FETCH;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MARK: begin
                if (stat.out_free) begin
                    cmd.load_mark = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_FETCH: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (stat.out_free) begin
                    cmd.load_mem = 1'b1;
                    state_next   = stat.burst_last ? ST_IDLE : ST_FETCH;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/wtps_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wtps_datapath (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wtps_pkg::in_beat_t  s_payload,
    input  wtps_pkg::ctl_cmd_t  cmd,
    output wtps_pkg::ctl_stat_t stat,
    output logic                m_valid,
    output wtps_pkg::out_beat_t m_payload,
    input  wire                 m_ready
);
    import wtps_pkg::*;

    logic [7:0] mem [MAX_WORD];

    logic [LEN_W-1:0]   stored_len_reg, stored_len_next;
    logic [LEN_W-1:0]   trim_len_reg, trim_len_next;
    logic               in_tag_reg, in_tag_next;
    logic               kept_reg, kept_next;
    logic               started_reg, started_next;
    logic               tag_p_reg, tag_p_next;
    logic               cut_reg, cut_next;
    logic               mark_cut_reg;
    logic [LEN_W-1:0]   burst_len_reg;
    logic [WORD_AW-1:0] rd_ptr_reg;
    logic [7:0]         rd_data_reg;
    logic               m_valid_reg;
    out_beat_t          out_reg;

    logic       is_lower, is_digit, is_slash, is_sp;
    logic       wr_en;
    logic       load_imm;
    plan_t      plan;
    out_beat_t  imm;
    out_beat_t  marker;

    assign is_lower = s_payload.ch inside {[8'h61:8'h7A]};
    assign is_digit = s_payload.ch inside {[8'h30:8'h39]};
    assign is_slash = (s_payload.ch == CH_SLASH);
    assign is_sp    = is_space(s_payload.ch);

    always_comb begin
        marker           = '0;
        marker.pair_end  = 1'b1;
        marker.truncated = cut_reg;
        marker.last      = 1'b1;
    end

    always_comb begin
        stored_len_next = stored_len_reg;
        trim_len_next   = trim_len_reg;
        in_tag_next     = in_tag_reg;
        kept_next       = kept_reg;
        started_next    = started_reg;
        tag_p_next      = tag_p_reg;
        cut_next        = cut_reg;
        wr_en           = 1'b0;
        plan            = PLAN_NONE;
        imm             = marker;

        if (s_payload.kind) begin
            // end of line: close an open tag, drop a pending word
            plan            = (in_tag_reg && kept_reg) ? PLAN_ONE : PLAN_NONE;
            stored_len_next = '0;
            trim_len_next   = '0;
            in_tag_next     = 1'b0;
            kept_next       = 1'b0;
            started_next    = 1'b0;
            tag_p_next      = 1'b0;
            cut_next        = 1'b0;
        end else if (in_tag_reg && is_lower) begin
            plan         = kept_reg ? PLAN_ONE : PLAN_NONE;
            imm          = '0;
            imm.out_byte = s_payload.ch;
            imm.is_tag   = 1'b1;
            imm.last     = 1'b1;
            if (!started_reg) begin
                started_next = 1'b1;
                tag_p_next   = (s_payload.ch == CH_P);
            end
        end else if (in_tag_reg && is_digit && tag_p_reg) begin
            // digit byte now, marker on the following beat
            plan         = kept_reg ? PLAN_TWO : PLAN_NONE;
            imm          = '0;
            imm.out_byte = s_payload.ch;
            imm.is_tag   = 1'b1;
            in_tag_next  = 1'b0;
            kept_next    = 1'b0;
            started_next = 1'b0;
            tag_p_next   = 1'b0;
            cut_next     = 1'b0;
        end else begin
            if (in_tag_reg) begin
                plan         = kept_reg ? PLAN_ONE : PLAN_NONE;
                in_tag_next  = 1'b0;
                kept_next    = 1'b0;
                started_next = 1'b0;
                tag_p_next   = 1'b0;
                cut_next     = 1'b0;
            end
            if (is_slash) begin
                kept_next       = (trim_len_reg != '0);
                if (trim_len_reg == '0) begin
                    cut_next = 1'b0;
                end
                if (!in_tag_reg && (trim_len_reg != '0)) begin
                    plan = PLAN_BURST;
                end
                stored_len_next = '0;
                trim_len_next   = '0;
                in_tag_next     = 1'b1;
                started_next    = 1'b0;
                tag_p_next      = 1'b0;
            end else if ((stored_len_reg == '0) && is_sp) begin
                // drop leading whitespace
            end else if (stored_len_reg == LEN_W'(MAX_WORD)) begin
                if (!is_sp) begin
                    cut_next = 1'b1;
                end
            end else begin
                wr_en           = 1'b1;
                stored_len_next = stored_len_reg + LEN_W'(1);
                if (!is_sp) begin
                    trim_len_next = stored_len_reg + LEN_W'(1);
                end
            end
        end
    end

    assign load_imm = cmd.accept && ((plan == PLAN_ONE) || (plan == PLAN_TWO));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_len_reg <= '0;
            trim_len_reg   <= '0;
            in_tag_reg     <= 1'b0;
            kept_reg       <= 1'b0;
            started_reg    <= 1'b0;
            tag_p_reg      <= 1'b0;
            cut_reg        <= 1'b0;
        end else if (cmd.accept) begin
            stored_len_reg <= stored_len_next;
            trim_len_reg   <= trim_len_next;
            in_tag_reg     <= in_tag_next;
            kept_reg       <= kept_next;
            started_reg    <= started_next;
            tag_p_reg      <= tag_p_next;
            cut_reg        <= cut_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && wr_en) begin
            mem[stored_len_reg[WORD_AW-1:0]] <= s_payload.ch;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mark_cut_reg  <= cut_reg;
            burst_len_reg <= trim_len_reg;
            rd_ptr_reg    <= '0;
        end else if (cmd.load_mem) begin
            rd_ptr_reg <= rd_ptr_reg + WORD_AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_imm || cmd.load_mark || cmd.load_mem) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_imm) begin
            out_reg <= imm;
        end else if (cmd.load_mark) begin
            out_reg <= '{out_byte: 8'h00, is_tag: 1'b0, pair_end: 1'b1,
                         truncated: mark_cut_reg, last: 1'b1};
        end else if (cmd.load_mem) begin
            out_reg <= '{out_byte: rd_data_reg, is_tag: 1'b0, pair_end: 1'b0,
                         truncated: 1'b0, last: stat.burst_last};
        end
    end

    assign stat.plan       = plan;
    assign stat.out_free   = !m_valid_reg || m_ready;
    assign stat.burst_last = (LEN_W'(rd_ptr_reg) + LEN_W'(1)) == burst_len_reg;

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

`ifndef ASSERT_OFF
    a_tag_empty_store: assert property (@(posedge aclk) disable iff (!aresetn)
        in_tag_reg |-> (stored_len_reg == '0))
        else $error("store not empty in tag phase");

    a_kept_in_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        kept_reg |-> in_tag_reg)
        else $error("pair kept outside tag phase");

    a_len_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (trim_len_reg <= stored_len_reg) && (stored_len_reg <= LEN_W'(MAX_WORD)))
        else $error("word lengths out of order");

    a_burst_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_mem |-> (LEN_W'(rd_ptr_reg) < burst_len_reg))
        else $error("burst read beyond word");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/word_tag_pair_splitter.sv =====
// Output: a tag byte, or a pair marker not closed by a digit, is presented the cycle after
//   its input beat; a closing digit's marker follows it, and word bytes are read then sent.
// Throughput: one input beat per cycle while the result side keeps up; a digit that
//   closes a tag holds the input until its marker is loaded; a slash that releases a word
//   of n bytes holds the input while each byte is read, then sent; stalls hold it longer.
// Reset: aresetn, synchronous, active low, clears state, lengths and valid; store kept.
`timescale 1ns / 1ps
`default_nettype none

module word_tag_pair_splitter (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wtps_pkg::in_beat_t  s_payload,
    output logic                m_valid,
    input  wire                 m_ready,
    output wtps_pkg::out_beat_t m_payload
);
    import wtps_pkg::*;

    // Command and status between sequencer and datapath
    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    // Sequencer: take a beat, then hold for a pair marker or a word burst
    wtps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: classify the byte, buffer the word, drive the result register
    wtps_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_payload (m_payload),
        .m_ready   (m_ready)
    );

endmodule

`default_nettype wire

// ===== tb/sv/wtps_pair_checker.sv =====
`timescale 1ns / 1ps

module wtps_pair_checker (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    input  wire                 s_ready,
    input  wtps_pkg::in_beat_t  s_payload,
    input  wire                 m_valid,
    input  wire                 m_ready,
    input  wtps_pkg::out_beat_t m_payload,
    output int                  fail_count,
    output int                  pending
);
    import wtps_pkg::*;

    // Mirror of the splitter state
    logic [7:0] word_mem [MAX_WORD];
    int         held_len;
    int         kept_len;
    bit         tag_phase;
    bit         word_kept;
    bit         tag_seen;
    bit         tag_p;
    bit         cut_seen;

    out_beat_t  step_beats[$];
    out_beat_t  expected_beats[$];

    function automatic bit is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic clear_pair_flags();
        tag_phase = 1'b0;
        word_kept = 1'b0;
        tag_seen  = 1'b0;
        tag_p     = 1'b0;
        cut_seen  = 1'b0;
    endtask

    task automatic add_result(input logic [7:0] b, input logic tag, input logic mark,
                              input logic cut);
        out_beat_t r;
        r.out_byte  = b;
        r.is_tag    = tag;
        r.pair_end  = mark;
        r.truncated = cut;
        r.last      = 1'b0;
        step_beats  = {step_beats, r};
    endtask

    // Close the pair: marker only when its word survived trimming
    task automatic finish_pair();
        if (word_kept) begin
            add_result(8'h00, 1'b0, 1'b1, cut_seen);
        end
        clear_pair_flags();
    endtask

    task automatic take_word_byte(input logic [7:0] c);
        int i;
        if (c == CH_SLASH) begin
            word_kept = (kept_len > 0);
            if (word_kept) begin
                for (i = 0; i < kept_len; i++) begin
                    add_result(word_mem[i], 1'b0, 1'b0, 1'b0);
                end
            end else begin
                cut_seen = 1'b0;
            end
            held_len  = 0;
            kept_len  = 0;
            tag_phase = 1'b1;
            tag_seen  = 1'b0;
            tag_p     = 1'b0;
        end else if (!(held_len == 0 && is_blank(c))) begin
            if (held_len >= MAX_WORD) begin
                if (!is_blank(c)) begin
                    cut_seen = 1'b1;
                end
            end else begin
                word_mem[held_len] = c;
                held_len++;
                if (!is_blank(c)) begin
                    kept_len = held_len;
                end
            end
        end
    endtask

    task automatic predict_pairs(input in_beat_t b);
        step_beats.delete();
        if (b.kind) begin
            if (tag_phase) begin
                finish_pair();
            end
            held_len = 0;
            kept_len = 0;
            clear_pair_flags();
        end else if (tag_phase) begin
            if (b.ch >= 8'h61 && b.ch <= 8'h7A) begin
                if (!tag_seen) begin
                    tag_seen = 1'b1;
                    tag_p    = (b.ch == CH_P);
                end
                if (word_kept) begin
                    add_result(b.ch, 1'b1, 1'b0, 1'b0);
                end
            end else if (b.ch >= 8'h30 && b.ch <= 8'h39 && tag_p) begin
                if (word_kept) begin
                    add_result(b.ch, 1'b1, 1'b0, 1'b0);
                end
                finish_pair();
            end else begin
                finish_pair();
                take_word_byte(b.ch);
            end
        end else begin
            take_word_byte(b.ch);
        end
        if (step_beats.size() > 0) begin
            step_beats[step_beats.size() - 1].last = 1'b1;
        end
        expected_beats = {expected_beats, step_beats};
    endtask

    task automatic check_result(input out_beat_t got);
        out_beat_t want;
        if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat byte=%h tag=%b end=%b cut=%b last=%b",
                got.out_byte, got.is_tag, got.pair_end, got.truncated, got.last));
        end else begin
            want = expected_beats.pop_front();
            if (got.out_byte !== want.out_byte || got.is_tag !== want.is_tag ||
                got.pair_end !== want.pair_end || got.truncated !== want.truncated ||
                got.last !== want.last) begin
                report_mismatch($sformatf(
                    "got byte=%h tag=%b end=%b cut=%b last=%b, want %h %b %b %b %b",
                    got.out_byte, got.is_tag, got.pair_end, got.truncated, got.last,
                    want.out_byte, want.is_tag, want.pair_end, want.truncated, want.last));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            held_len   = 0;
            kept_len   = 0;
            fail_count = 0;
            clear_pair_flags();
            expected_beats.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_payload);
            end
            if (s_valid && s_ready) begin
                predict_pairs(s_payload);
            end
        end
        pending = expected_beats.size();
    end

endmodule

// ===== tb/sv/word_tag_pair_splitter_test.sv =====
`timescale 1ns / 1ps

module word_tag_pair_splitter_test;
    import wtps_pkg::*;

    // Characters used to build text lines
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    // Longest receiver hold-off, and cycles without any beat before giving up
    localparam int HOLD_LEN   = 200;
    localparam int STALL_STOP = 4000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_payload;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_payload;

    int        fail_count;
    int        pending;

    int        send_idle_pct;
    int        recv_stall_pct;
    logic      hold_go;
    int        hold_cycles = 0;
    int        sent_beats = 0;
    int        stall_cycles;

    int        idle_by_phase[4]  = '{0, 45, 0, 23};
    int        stall_by_phase[4] = '{0, 0, 45, 23};

    word_tag_pair_splitter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    wtps_pair_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Receiver: one long hold-off when asked for, otherwise random stalls
    always @(posedge aclk) begin
        if (hold_go && hold_cycles < HOLD_LEN) begin
            m_ready     <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: stop the run when no beat moves on either channel for too long
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_STOP) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    // Offer one beat, idling first at random; return at the edge that takes it.
    // Valid stays high into the next beat unless an idle cycle comes first.
    task automatic send_beat(input logic kind, input logic [7:0] ch);
        in_beat_t b;
        b.kind = kind;
        b.ch   = ch;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_beats++;
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) begin
            send_beat(1'b0, t[i]);
        end
    endtask

    // End of line; the byte field is ignored, so fill it at random
    task automatic send_eol();
        send_beat(1'b1, 8'($urandom_range(255)));
    endtask

    // Drop valid and hold until every predicted beat has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // Word content: mostly letters, some blanks, some arbitrary bytes (never a slash)
    function automatic logic [7:0] pick_word_byte();
        logic [7:0] c;
        int         roll;
        roll = $urandom_range(99);
        if (roll < 70) begin
            c = CH_A + 8'($urandom_range(25));
        end else if (roll < 80) begin
            c = pick_blank();
        end else begin
            c = 8'($urandom_range(255));
            if (c == CH_SLASH) begin
                c = CH_DOT;
            end
        end
        return c;
    endfunction

    // One well-formed word/tag pair with random content and a random ending
    task automatic send_random_pair(input bit long_word);
        int         n;
        logic [7:0] c;
        bit         starts_p;
        bit         closed;
        int         roll;
        starts_p = 1'b0;
        closed   = 1'b0;
        repeat ($urandom_range(2)) send_beat(1'b0, pick_blank());
        n = long_word ? int'($urandom_range(70, 66)) : int'($urandom_range(6, 1));
        repeat (n) send_beat(1'b0, pick_word_byte());
        repeat ($urandom_range(2)) send_beat(1'b0, pick_blank());
        // A word with no slash is thrown away at end of line
        if (!long_word && $urandom_range(11) == 0) begin
            send_eol();
        end else begin
            send_beat(1'b0, CH_SLASH);
            n = $urandom_range(4);
            for (int k = 0; k < n; k++) begin
                if (k == 0 && $urandom_range(2) == 0) begin
                    c = CH_P;
                end else begin
                    c = CH_A + 8'($urandom_range(25));
                end
                if (k == 0) begin
                    starts_p = (c == CH_P);
                end
                send_beat(1'b0, c);
            end
            if (starts_p && $urandom_range(1) == 1) begin
                send_beat(1'b0, CH_ZERO + 8'($urandom_range(9)));
                closed = 1'b1;
            end
            if (!closed) begin
                roll = $urandom_range(99);
                if (roll < 40) begin
                    send_beat(1'b0, pick_blank());
                end else if (roll < 55) begin
                    send_beat(1'b0, ($urandom_range(1) == 1) ? CH_DASH : CH_COMMA);
                end else if (roll < 70) begin
                    send_eol();
                end else if (roll < 80) begin
                    send_beat(1'b0, CH_ZERO + 8'($urandom_range(9)));
                end
                // otherwise the next word runs straight into the tag
            end
        end
    endtask

    // Arbitrary beats, end of line now and then
    task automatic send_noise();
        repeat ($urandom_range(4, 1)) begin
            send_beat(($urandom_range(7) == 0), 8'($urandom_range(255)));
        end
    endtask

    initial begin
        int pairs;
        int start_beats;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_payload      = '0;
        hold_go        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Leading and trailing blanks trimmed; comma ends the pair and starts a word
        send_text(" ab \t/nn,");
        // Tag opened by p closed by a digit
        send_text("/p3");
        // Blank-only word: whole pair dropped; digit after a non-p tag starts a word
        send_text("  /x9");
        // Slash in tag phase: empty tag, then a dropped pair
        send_text("//");
        // Byte extremes inside a word, then end of line closes the open tag
        send_beat(1'b0, 8'hFF);
        send_beat(1'b0, 8'h00);
        send_beat(1'b0, CH_SLASH);
        send_eol();
        // End of line with nothing open
        send_beat(1'b1, 8'hFF);
        send_beat(1'b1, 8'h00);
        // Word never closed by a slash is discarded
        send_text("zz");
        send_eol();
        wait_drained();

        // Hold the receiver off while the sender keeps offering beats
        send_idle_pct = 0;
        hold_go <= 1'b1;
        send_text("ab/c ");
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_by_phase[ph];
            recv_stall_pct = stall_by_phase[ph];
            pairs          = 0;
            start_beats    = sent_beats;
            while (sent_beats - start_beats < 8) begin
                if ($urandom_range(9) == 0) begin
                    send_noise();
                end else begin
                    // Overfill the word buffer once, in the first phase
                    send_random_pair(ph == 0 && pairs == 0);
                    pairs++;
                end
            end
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
